// ===== hdl/i2cee_pkg.sv =====
package i2cee_pkg;

   // Storage sizes.
   localparam int MemDepth = 65536;
   localparam int MemAw = $clog2(MemDepth);
   localparam int IdDepth = 32;
   localparam int IdAw = $clog2(IdDepth);
   localparam int CsrAw = 3;

   // Chip type codes that change the addressing.
   localparam logic [3:0] ChipX24C01 = 4'd1;
   localparam logic [3:0] ChipM24C16 = 4'd6;

   // Device nibbles.
   localparam logic [3:0] AreaMem = 4'hA;
   localparam logic [3:0] AreaId = 4'hB;

   // Configuration register indexes.
   localparam logic RegChipType = 1'b0;
   localparam logic RegWriteEnable = 1'b1;

   localparam logic [7:0] ErasedByte = 8'hFF;

   typedef enum logic [2:0] {
      PhStandby,
      PhDevice,
      PhBank,
      PhAddress,
      PhRead,
      PhWrite
   } phase_type;

   // Parts up to M24C16 carry block bits in the device byte.
   function automatic logic small_part(input logic [3:0] ct);
      return ct <= ChipM24C16;
   endfunction

   // Address mask of each part; unknown parts only see the memory size.
   function automatic logic [22:0] chip_mask(input logic [3:0] ct);
      logic [22:0] mask;
      case (ct)
         4'd1, 4'd2: mask = 23'h00007F;
         4'd3:       mask = 23'h0000FF;
         4'd4:       mask = 23'h0001FF;
         4'd5:       mask = 23'h0003FF;
         4'd6:       mask = 23'h0007FF;
         4'd7:       mask = 23'h000FFF;
         4'd8, 4'd9: mask = 23'h001FFF;
         4'd10:      mask = 23'h003FFF;
         4'd11:      mask = 23'h007FFF;
         4'd12:      mask = 23'h00FFFF;
         default:    mask = 23'h7FFFFF;
      endcase
      return mask;
   endfunction

   // Byte offset into the memory array for the current addressing mode.
   function automatic logic [MemAw-1:0] mem_index(input logic [3:0] ct,
                                                  input logic [7:0] dev,
                                                  input logic [7:0] bank,
                                                  input logic [7:0] wa);
      logic [22:0] off;
      logic [22:0] masked;
      if (ct == ChipX24C01) begin
         off = {16'b0, wa[7:1]};
      end else if (small_part(ct)) begin
         off = {8'b0, dev[7:1], wa};
      end else begin
         off = {dev[7:1], bank, wa};
      end
      masked = off & chip_mask(ct);
      return masked[MemAw-1:0];
   endfunction

endpackage

// ===== hdl/i2cee_ram.sv =====
module i2cee_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Single port: write on request, read data registered every cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/i2c_serial_eeprom_slave.sv =====
// I2C serial EEPROM slave of the 24Cxx kind, driven by sampled bus levels.
// Input channel (req_): one transfer carries one sample of SCL and SDA.
// Result channel (rsp_): one transfer per input sample, carrying the SDA
// level the slave presents (the input SDA while in standby).
// Configuration (csr_): APB-style; chip_type at 0x0, write_enable at 0x4.
// The result of a sample is registered in the output buffer and offered
// once earlier results are taken. One sample is taken every cycle while
// req_ready is high; each sample makes at most one access to the byte
// memory, a synchronous RAM with registered read data, and the fetched byte
// is captured in the following cycle. After reset the block sweeps the
// 65536-byte memory and the 32-byte ID page to the erased value 0xFF, one
// entry per cycle, and req_ready stays low until the sweep is done;
// configuration writes are taken during the sweep. A two-entry output
// buffer lets samples keep flowing while a result waits. When the receiver
// stalls and both entries are full, req_ready drops until a result is taken.
module i2c_serial_eeprom_slave (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_scl,
   input  logic                        req_sda,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_sda_out,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [i2cee_pkg::CsrAw-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   // Configuration registers.
   logic [3:0] chip_type_ff, chip_type_in;
   logic       write_enable_ff, write_enable_in;

   // Protocol state.
   i2cee_pkg::phase_type phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] device_byte_ff, device_byte_in;
   logic [7:0] bank_byte_ff, bank_byte_in;
   logic [7:0] word_address_ff, word_address_in;
   logic [7:0] shift_in_ff, shift_in_in;
   logic [7:0] read_byte_ff, read_byte_in;
   logic       response_bit_ff, response_bit_in;
   logic       scl_last_ff, scl_last_in;
   logic       sda_last_ff, sda_last_in;
   logic       rd_pend_ff, rd_pend_in;
   logic       rd_from_id_ff, rd_from_id_in;

   // Erase sweep after reset.
   logic                        clr_busy_ff, clr_busy_in;
   logic [i2cee_pkg::MemAw-1:0] clr_cnt_ff, clr_cnt_in;

   // Output buffer.
   logic       out0_ff, out0_in;
   logic       out1_ff, out1_in;
   logic [1:0] ocnt_ff, ocnt_in;

   // Memory ports.
   logic                        mem_we;
   logic [i2cee_pkg::MemAw-1:0] mem_addr;
   logic [7:0]                  mem_wdata;
   logic [7:0]                  mem_rdata;
   logic                        id_we;
   logic [i2cee_pkg::IdAw-1:0]  id_addr;
   logic [7:0]                  id_wdata;
   logic [7:0]                  id_rdata;

   // Per-sample decode.
   logic                        req_take;
   logic                        rsp_take;
   logic                        cfg_write;
   logic                        scl_high, scl_fall, scl_rise, sda_fall, sda_rise;
   logic                        small_chip;
   logic [3:0]                  area;
   logic [7:0]                  wa_step;
   logic [7:0]                  bank_step;
   logic [i2cee_pkg::MemAw-1:0] idx_cur;
   logic [i2cee_pkg::MemAw-1:0] idx_step;
   logic [3:0]                  bit_sel;
   logic                        read_bit;
   logic                        data_bit;
   logic                        result_bit;

   i2cee_ram #(
      .Width(8),
      .Depth(i2cee_pkg::MemDepth)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .addr   (mem_addr),
      .wr_data(mem_wdata),
      .rd_data(mem_rdata)
   );

   i2cee_ram #(
      .Width(8),
      .Depth(i2cee_pkg::IdDepth)
   ) u_id (
      .clock  (clock),
      .wr_en  (id_we),
      .addr   (id_addr),
      .wr_data(id_wdata),
      .rd_data(id_rdata)
   );

   // Handshakes.
   assign req_ready = !clr_busy_ff && (ocnt_ff != 2'd2);
   assign req_take = req_valid && req_ready;
   assign rsp_valid = (ocnt_ff != 2'd0);
   assign rsp_take = rsp_valid && rsp_ready;
   assign rsp_sda_out = out0_ff;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == i2cee_pkg::RegWriteEnable) ?
                       {31'b0, write_enable_ff} : {28'b0, chip_type_ff};

   always_comb begin
      chip_type_in = chip_type_ff;
      write_enable_in = write_enable_ff;
      if (cfg_write) begin
         unique case (csr_paddr[2])
            i2cee_pkg::RegChipType:    chip_type_in = csr_pwdata[3:0];
            i2cee_pkg::RegWriteEnable: write_enable_in = csr_pwdata[0];
            default:                   chip_type_in = chip_type_ff;
         endcase
      end
   end

   // Edge detection against the previous sample and address helpers.
   assign scl_high = scl_last_ff && req_scl;
   assign scl_fall = scl_last_ff && !req_scl;
   assign scl_rise = !scl_last_ff && req_scl;
   assign sda_fall = sda_last_ff && !req_sda;
   assign sda_rise = !sda_last_ff && req_sda;
   assign small_chip = i2cee_pkg::small_part(chip_type_ff);
   assign area = device_byte_ff[7:4];
   assign wa_step = word_address_ff +
                    ((chip_type_ff == i2cee_pkg::ChipX24C01) ? 8'd2 : 8'd1);
   assign bank_step = (wa_step == 8'd0) ? bank_byte_ff + 8'd1 : bank_byte_ff;
   assign idx_cur = i2cee_pkg::mem_index(chip_type_ff, device_byte_ff,
                                         bank_byte_ff, word_address_ff);
   assign idx_step = i2cee_pkg::mem_index(chip_type_ff, device_byte_ff,
                                          bank_step, wa_step);
   assign data_bit = bit_count_ff <= 4'd8;
   assign bit_sel = 4'd8 - bit_count_ff;
   assign read_bit = bit_sel[3] ? 1'b0 : read_byte_ff[bit_sel[2:0]];

   // Bus protocol: start/stop, bit counting and the byte phases.
   always_comb begin
      phase_in = phase_ff;
      bit_count_in = bit_count_ff;
      device_byte_in = device_byte_ff;
      bank_byte_in = bank_byte_ff;
      word_address_in = word_address_ff;
      shift_in_in = shift_in_ff;
      response_bit_in = response_bit_ff;
      scl_last_in = scl_last_ff;
      sda_last_in = sda_last_ff;
      rd_pend_in = 1'b0;
      rd_from_id_in = rd_from_id_ff;
      mem_we = 1'b0;
      mem_addr = idx_cur;
      mem_wdata = shift_in_ff;
      id_we = 1'b0;
      id_addr = word_address_ff[i2cee_pkg::IdAw-1:0];
      id_wdata = shift_in_ff;

      if (req_take) begin
         scl_last_in = req_scl;
         sda_last_in = req_sda;

         // Start and stop conditions.
         if (scl_high) begin
            if (sda_fall) begin
               bit_count_in = 4'd0;
               phase_in = (chip_type_ff == i2cee_pkg::ChipX24C01) ?
                          i2cee_pkg::PhAddress : i2cee_pkg::PhDevice;
            end else if (sda_rise) begin
               bit_count_in = 4'd0;
               phase_in = i2cee_pkg::PhStandby;
            end
         end

         // Bit counting on falling SCL: eight data bits per byte, then the acknowledge slot.
         if (scl_fall) begin
            bit_count_in = (bit_count_ff > 4'd8) ? 4'd1 : bit_count_ff + 4'd1;
         end

         if (scl_rise) begin
            unique case (phase_ff)
               i2cee_pkg::PhDevice: begin
                  if (data_bit) begin
                     device_byte_in = {device_byte_ff[6:0], req_sda};
                  end else if (!((area == i2cee_pkg::AreaMem) ||
                                 (area == i2cee_pkg::AreaId && !small_chip))) begin
                     phase_in = i2cee_pkg::PhStandby;
                  end else if (device_byte_ff[0]) begin
                     // Read select: fetch the first byte.
                     phase_in = i2cee_pkg::PhRead;
                     response_bit_in = 1'b0;
                     rd_pend_in = 1'b1;
                     rd_from_id_in = (area == i2cee_pkg::AreaId);
                  end else begin
                     phase_in = small_chip ? i2cee_pkg::PhAddress : i2cee_pkg::PhBank;
                     response_bit_in = 1'b0;
                  end
               end
               i2cee_pkg::PhBank: begin
                  if (data_bit) begin
                     bank_byte_in = {bank_byte_ff[6:0], req_sda};
                  end else begin
                     phase_in = i2cee_pkg::PhAddress;
                     response_bit_in = 1'b0;
                  end
               end
               i2cee_pkg::PhAddress: begin
                  if (data_bit) begin
                     word_address_in = {word_address_ff[6:0], req_sda};
                  end else if (chip_type_ff == i2cee_pkg::ChipX24C01 &&
                               word_address_ff[0]) begin
                     // The small part takes its read bit in the address byte.
                     phase_in = i2cee_pkg::PhRead;
                     if (area == i2cee_pkg::AreaMem) begin
                        response_bit_in = 1'b0;
                        rd_pend_in = 1'b1;
                        rd_from_id_in = 1'b0;
                     end else begin
                        response_bit_in = 1'b1;
                     end
                  end else begin
                     phase_in = i2cee_pkg::PhWrite;
                     response_bit_in = 1'b0;
                  end
               end
               i2cee_pkg::PhRead: begin
                  if (data_bit) begin
                     response_bit_in = read_bit;
                  end else if (!req_sda) begin
                     // Master acknowledged: advance and fetch the next byte.
                     word_address_in = wa_step;
                     bank_byte_in = bank_step;
                     mem_addr = idx_step;
                     id_addr = wa_step[i2cee_pkg::IdAw-1:0];
                     if (area == i2cee_pkg::AreaMem ||
                         (area == i2cee_pkg::AreaId && !small_chip)) begin
                        response_bit_in = 1'b0;
                        rd_pend_in = 1'b1;
                        rd_from_id_in = (area == i2cee_pkg::AreaId);
                     end else begin
                        response_bit_in = 1'b1;
                     end
                  end else begin
                     phase_in = i2cee_pkg::PhStandby;
                  end
               end
               i2cee_pkg::PhWrite: begin
                  if (data_bit) begin
                     shift_in_in = {shift_in_ff[6:0], req_sda};
                  end else begin
                     // Store the byte at the current address unless writes are refused, then advance.
                     if (area == i2cee_pkg::AreaMem && write_enable_ff) begin
                        mem_we = 1'b1;
                        response_bit_in = 1'b0;
                     end else if (area == i2cee_pkg::AreaId && write_enable_ff &&
                                  !small_chip) begin
                        id_we = 1'b1;
                        response_bit_in = 1'b0;
                     end else begin
                        response_bit_in = 1'b1;
                     end
                     word_address_in = wa_step;
                     bank_byte_in = bank_step;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end

      // The erase sweep owns both memories until it is done.
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_addr = clr_cnt_ff;
         mem_wdata = i2cee_pkg::ErasedByte;
         id_we = (clr_cnt_ff[i2cee_pkg::MemAw-1:i2cee_pkg::IdAw] == '0);
         id_addr = clr_cnt_ff[i2cee_pkg::IdAw-1:0];
         id_wdata = i2cee_pkg::ErasedByte;
      end
   end

   // Sweep counter; the last entry is the all-ones address.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // Capture the fetched byte in the cycle after the read was issued.
   assign read_byte_in = rd_pend_ff ? (rd_from_id_ff ? id_rdata : mem_rdata) :
                         read_byte_ff;

   // Result of the accepted sample and the two-entry output buffer.
   assign result_bit = (phase_in == i2cee_pkg::PhStandby) ? req_sda : response_bit_in;

   always_comb begin
      out0_in = out0_ff;
      out1_in = out1_ff;
      ocnt_in = ocnt_ff;
      if (req_take && !rsp_take) begin
         if (ocnt_ff == 2'd0) begin
            out0_in = result_bit;
         end else begin
            out1_in = result_bit;
         end
         ocnt_in = ocnt_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         out0_in = out1_ff;
         ocnt_in = ocnt_ff - 2'd1;
      end else if (rsp_take && req_take) begin
         if (ocnt_ff == 2'd1) begin
            out0_in = result_bit;
         end else begin
            out0_in = out1_ff;
            out1_in = result_bit;
         end
      end
   end

   // Phase register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cee_pkg::PhStandby;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Control and protocol registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_type_ff <= 4'd0;
         write_enable_ff <= 1'b1;
         bit_count_ff <= 4'd0;
         device_byte_ff <= 8'hA0;
         bank_byte_ff <= 8'd0;
         word_address_ff <= 8'd0;
         shift_in_ff <= 8'd0;
         read_byte_ff <= 8'd0;
         response_bit_ff <= 1'b0;
         scl_last_ff <= 1'b1;
         sda_last_ff <= 1'b1;
         rd_pend_ff <= 1'b0;
         rd_from_id_ff <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff <= '0;
         ocnt_ff <= 2'd0;
      end else begin
         chip_type_ff <= chip_type_in;
         write_enable_ff <= write_enable_in;
         bit_count_ff <= bit_count_in;
         device_byte_ff <= device_byte_in;
         bank_byte_ff <= bank_byte_in;
         word_address_ff <= word_address_in;
         shift_in_ff <= shift_in_in;
         read_byte_ff <= read_byte_in;
         response_bit_ff <= response_bit_in;
         scl_last_ff <= scl_last_in;
         sda_last_ff <= sda_last_in;
         rd_pend_ff <= rd_pend_in;
         rd_from_id_ff <= rd_from_id_in;
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff <= clr_cnt_in;
         ocnt_ff <= ocnt_in;
      end
   end

   // Output buffer payload.
   always_ff @(posedge clock) begin
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

endmodule

// ===== tb/sv/i2c_serial_eeprom_slave_tb.sv =====
module i2c_serial_eeprom_slave_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 800000;
   localparam int SegmentSamples = 12;

   // Memory size of each chip code; zero means only the array size limits the offset.
   localparam int unsigned PartBytes [0:15] = '{
      0, 128, 128, 256, 512, 1024, 2048, 4096,
      8192, 8192, 16384, 32768, 65536, 0, 0, 0
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_scl = 1'b1;
   logic req_sda = 1'b1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_sda_out;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [i2cee_pkg::CsrAw-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Predicts the SDA level the slave presents for every bus sample it takes.
   class eeprom_predictor;
      bit [3:0] chip;
      bit writes_on;
      i2cee_pkg::phase_type ph;
      bit [3:0] bits_seen;
      bit [7:0] dev_byte;
      bit [7:0] bank;
      bit [7:0] waddr;
      bit [7:0] wdata;
      bit [7:0] rdata;
      bit resp;
      bit scl_prev;
      bit sda_prev;
      bit [7:0] cells [i2cee_pkg::MemDepth];
      bit [7:0] id_cells [i2cee_pkg::IdDepth];
      bit sda_due [$];
      int mismatches;

      function new();
         chip = 4'd0;
         writes_on = 1'b1;
         ph = i2cee_pkg::PhStandby;
         bits_seen = 4'd0;
         dev_byte = {i2cee_pkg::AreaMem, 4'h0};
         bank = 8'h00;
         waddr = 8'h00;
         wdata = 8'h00;
         rdata = 8'h00;
         resp = 1'b0;
         scl_prev = 1'b1;
         sda_prev = 1'b1;
         mismatches = 0;
         foreach (cells[i]) cells[i] = i2cee_pkg::ErasedByte;
         foreach (id_cells[i]) id_cells[i] = i2cee_pkg::ErasedByte;
      endfunction

      function void set_register(input logic reg_idx, input logic [31:0] value);
         if (reg_idx == i2cee_pkg::RegChipType) chip = value[3:0];
         else writes_on = value[0];
      endfunction

      function bit narrow_part();
         return chip <= i2cee_pkg::ChipM24C16;
      endfunction

      // Byte offset of the current address, limited by part size and array size.
      function int unsigned cell_offset();
         int unsigned off;
         int unsigned span;
         if (chip == i2cee_pkg::ChipX24C01) off = waddr[7:1];
         else if (narrow_part()) off = {dev_byte[7:1], waddr};
         else off = {dev_byte[7:1], bank, waddr};
         span = PartBytes[chip];
         off = off & (span - 1);
         return off & (i2cee_pkg::MemDepth - 1);
      endfunction

      // The memory always answers; the ID page only on the larger parts.
      function bit device_acks();
         if (dev_byte[7:4] == i2cee_pkg::AreaMem) return 1'b1;
         if (dev_byte[7:4] == i2cee_pkg::AreaId) return !narrow_part();
         return 1'b0;
      endfunction

      // Loads the next byte to shift out; returns the acknowledge level.
      function bit load_byte();
         if (dev_byte[7:4] == i2cee_pkg::AreaMem) begin
            rdata = cells[cell_offset()];
            return 1'b0;
         end
         if (dev_byte[7:4] == i2cee_pkg::AreaId && !narrow_part()) begin
            rdata = id_cells[waddr[i2cee_pkg::IdAw-1:0]];
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // Stores the received byte unless writes are refused.
      function bit save_byte();
         if (dev_byte[7:4] == i2cee_pkg::AreaMem && writes_on) begin
            cells[cell_offset()] = wdata;
            return 1'b0;
         end
         if (dev_byte[7:4] == i2cee_pkg::AreaId && writes_on && !narrow_part()) begin
            id_cells[waddr[i2cee_pkg::IdAw-1:0]] = wdata;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void advance_address();
         waddr = waddr + ((chip == i2cee_pkg::ChipX24C01) ? 8'd2 : 8'd1);
         if (waddr == 8'h00) bank = bank + 8'd1;
      endfunction

      function void take_sample(input bit scl, input bit sda);
         bit clk_high;
         bit clk_fall;
         bit clk_rise;
         bit data_bit;
         int unsigned shifted;
         i2cee_pkg::phase_type held;
         clk_high = scl_prev & scl;
         clk_fall = scl_prev & ~scl;
         clk_rise = ~scl_prev & scl;
         held = ph;

         // Start and stop conditions: SDA moves while SCL stays high.
         if (clk_high && sda_prev && !sda) begin
            bits_seen = 4'd0;
            ph = (chip == i2cee_pkg::ChipX24C01) ? i2cee_pkg::PhAddress :
                                                   i2cee_pkg::PhDevice;
         end else if (clk_high && !sda_prev && sda) begin
            bits_seen = 4'd0;
            ph = i2cee_pkg::PhStandby;
         end

         // Eight data bits per byte, then the acknowledge slot, counted on falling SCL.
         if (clk_fall) bits_seen = (bits_seen > 4'd8) ? 4'd1 : bits_seen + 4'd1;

         // Rising SCL runs the phase that was held before the start/stop check.
         if (clk_rise) begin
            data_bit = bits_seen <= 4'd8;
            case (held)
               i2cee_pkg::PhDevice: begin
                  if (data_bit) begin
                     dev_byte = {dev_byte[6:0], sda};
                  end else if (!device_acks()) begin
                     ph = i2cee_pkg::PhStandby;
                  end else if (dev_byte[0]) begin
                     ph = i2cee_pkg::PhRead;
                     resp = load_byte();
                  end else begin
                     ph = narrow_part() ? i2cee_pkg::PhAddress : i2cee_pkg::PhBank;
                     resp = 1'b0;
                  end
               end
               i2cee_pkg::PhBank: begin
                  if (data_bit) begin
                     bank = {bank[6:0], sda};
                  end else begin
                     ph = i2cee_pkg::PhAddress;
                     resp = 1'b0;
                  end
               end
               i2cee_pkg::PhAddress: begin
                  if (data_bit) begin
                     waddr = {waddr[6:0], sda};
                  end else if (chip == i2cee_pkg::ChipX24C01 && waddr[0]) begin
                     ph = i2cee_pkg::PhRead;
                     resp = load_byte();
                  end else begin
                     ph = i2cee_pkg::PhWrite;
                     resp = 1'b0;
                  end
               end
               i2cee_pkg::PhRead: begin
                  if (data_bit) begin
                     shifted = 32'(rdata) >> (8 - int'(bits_seen));
                     resp = shifted[0];
                  end else if (!sda) begin
                     advance_address();
                     resp = load_byte();
                  end else begin
                     ph = i2cee_pkg::PhStandby;
                  end
               end
               i2cee_pkg::PhWrite: begin
                  if (data_bit) begin
                     wdata = {wdata[6:0], sda};
                  end else begin
                     resp = save_byte();
                     advance_address();
                  end
               end
               default: ;
            endcase
         end

         scl_prev = scl;
         sda_prev = sda;
         sda_due.push_back((ph == i2cee_pkg::PhStandby) ? sda : resp);
      endfunction

      function void check_sda(input logic actual);
         bit wanted;
         if (sda_due.size() == 0) begin
            $display("%0t: result with nothing expected, sda_out %b", $time, actual);
            mismatches++;
            return;
         end
         wanted = sda_due.pop_front();
         if (actual !== wanted) begin
            $display("%0t: sda_out mismatch, expected %b, actual %b", $time, wanted, actual);
            mismatches++;
         end
      endfunction
   endclass

   eeprom_predictor predictor;
   int cycle_count = 0;
   int samples_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   logic [3:0] chip_now = 4'd0;

   i2c_serial_eeprom_slave dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_scl    (req_scl),
      .req_sda    (req_sda),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sda_out(rsp_sda_out),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #4 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: check each transfer, then choose the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) predictor.check_sda(rsp_sda_out);
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one bus sample and waits for its transfer, then maybe idles.
   task automatic send_sample(input bit scl, input bit sda);
      int gap;
      req_valid <= 1'b1;
      req_scl <= scl;
      req_sda <= sda;
      do @(posedge clock); while (!req_ready);
      predictor.take_sample(scl, sda);
      samples_sent++;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic bus_start();
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
   endtask

   task automatic bus_stop();
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
   endtask

   // SDA is set while SCL is low; the next low sample makes the falling edge.
   task automatic bus_bit(input bit level);
      send_sample(1'b0, level);
      send_sample(1'b1, level);
   endtask

   // Eight data bits, most significant first, then the acknowledge clock.
   task automatic bus_byte(input logic [7:0] value, input bit ack_level);
      for (int i = 7; i >= 0; i--) bus_bit(value[i]);
      bus_bit(ack_level);
   endtask

   // Stops offering and waits until every expected result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (predictor.sda_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= i2cee_pkg::CsrAw'({reg_idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      predictor.set_register(reg_idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [3:0] chip, input bit we);
      drain();
      csr_write(i2cee_pkg::RegChipType, 32'(chip));
      csr_write(i2cee_pkg::RegWriteEnable, 32'(we));
      chip_now = chip;
   endtask

   // One bus exchange: mostly well-formed writes and reads, some broken or noise.
   task automatic random_exchange();
      int pick;
      int count;
      int sel;
      bit x24;
      bit narrow;
      bit nak_last;
      logic [3:0] area;
      logic [2:0] blk;
      logic [7:0] bank;
      logic [7:0] addr;
      pick = $urandom_range(99);
      x24 = (chip_now == i2cee_pkg::ChipX24C01);
      narrow = (chip_now <= i2cee_pkg::ChipM24C16);
      count = $urandom_range(1, 2);
      nak_last = ($urandom_range(4) != 0);

      sel = $urandom_range(99);
      if (sel < 85) area = i2cee_pkg::AreaMem;
      else if (sel < 93) area = i2cee_pkg::AreaId;
      else area = 4'($urandom);
      blk = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(1));
      sel = $urandom_range(3);
      bank = (sel == 0) ? 8'hFF : (sel == 1) ? 8'($urandom) : 8'h00;
      sel = $urandom_range(5);
      if (sel < 3) addr = 8'($urandom_range(7));
      else if (sel == 3) addr = 8'hFF;
      else if (sel == 4) addr = 8'hFE;
      else addr = 8'($urandom);

      if (pick < 35) begin
         // Write: device, optional bank, address, then data bytes.
         bus_start();
         if (x24) begin
            bus_byte({addr[6:0], 1'b0}, 1'b1);
         end else begin
            bus_byte({area, blk, 1'b0}, 1'b1);
            if (!narrow) bus_byte(bank, 1'b1);
            bus_byte(addr, 1'b1);
         end
         repeat (count) bus_byte(8'($urandom), 1'b1);
         bus_stop();
      end else if (pick < 70) begin
         // Read, usually after setting the address with a repeated start.
         bus_start();
         if (x24) begin
            bus_byte({addr[6:0], 1'b1}, 1'b1);
         end else begin
            if ($urandom_range(9) < 7) begin
               bus_byte({area, blk, 1'b0}, 1'b1);
               if (!narrow) bus_byte(bank, 1'b1);
               bus_byte(addr, 1'b1);
               bus_start();
            end
            bus_byte({area, blk, 1'b1}, 1'b1);
         end
         for (int i = 0; i < count; i++) begin
            bus_byte(8'($urandom), (i == count - 1) ? nak_last : 1'b0);
         end
         bus_stop();
      end else if (pick < 85) begin
         // Broken exchange: a start, a few stray bits, and maybe a stop.
         bus_start();
         repeat ($urandom_range(1, 14)) bus_bit(1'($urandom_range(1)));
         if ($urandom_range(1) != 0) bus_stop();
      end else begin
         repeat ($urandom_range(1, 12)) begin
            send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      int seg_start;
      predictor = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: every SCL/SDA level pair, start and stop, stray clocks.
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      bus_start();
      bus_bit(1'b1);
      bus_bit(1'b0);
      bus_stop();

      // Long receiver hold-off while the sender keeps offering samples.
      hold_left <= 300;
      repeat (2) random_exchange();
      drain();

      // Random segments: every chip code, both write settings, all idle modes.
      for (int seg = 0; seg < 16; seg++) begin
         set_config(4'(seg), (seg % 3) != 2);
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         seg_start = samples_sent;
         while (samples_sent - seg_start < SegmentSamples) random_exchange();
      end

      drain();
      repeat (8) @(posedge clock);
      if (predictor.sda_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, predictor.sda_due.size());
      end
      if (predictor.mismatches == 0 && predictor.sda_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/i2cee_pkg.sv
hdl/i2cee_ram.sv
hdl/i2c_serial_eeprom_slave.sv
tb/sv/i2c_serial_eeprom_slave_tb.sv
